// ===== design/sfr_pkg.sv =====
// Shared types and constants for the streaming find-and-replace block.
// Used by sfr_match and stream_find_replace; depends on nothing else.
package sfr_pkg;

    // Fixed widths from the field definitions
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 4;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned RIDX_W   = 3;
    localparam int unsigned NCNT_W   = 4;

    // Most results one input beat may produce; extras are dropped
    localparam logic [NCNT_W-1:0] RESULT_LIMIT = 4'd9;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } cfg_idx_t;

    // Input beat
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_final;
    } in_beat_t;

    // Output beat
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              run_last;
        logic              string_end;
    } out_beat_t;

    // Compare result of held bytes against the pattern
    typedef struct packed {
        logic full;     // held bytes start with the whole pattern
        logic partial;  // held bytes are a proper prefix of the pattern
    } match_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_CHECK,
        ST_REPL,
        ST_FLUSH,
        ST_FINISH
    } state_t;

endpackage

// ===== design/sfr_match.sv =====
// Prefix compare unit: checks the held bytes against the search pattern.
// Depends on sfr_pkg for widths and the match_t result struct.
module sfr_match #(
    parameter int unsigned PATTERN_MAX = 8
) (
    input  logic [PATTERN_MAX-1:0][sfr_pkg::BYTE_W-1:0] held,
    input  logic [sfr_pkg::LEN_W-1:0]                   count,
    input  logic [sfr_pkg::LEN_W-1:0]                   plen,
    input  logic [sfr_pkg::WORD_W-1:0]                  pattern,
    output sfr_pkg::match_t                             result
);

    logic [sfr_pkg::LEN_W-1:0] lim;
    logic                      all_eq;

    // compare only the first min(count, plen) bytes
    assign lim = (count < plen) ? count : plen;

    always_comb
    begin
        all_eq = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (sfr_pkg::LEN_W'(i) < lim &&
                held[i] != pattern[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W])
            begin
                all_eq = 1'b0;
            end
        end
    end

    assign result.full    = (plen != '0) && (count >= plen) && all_eq;
    assign result.partial = (plen != '0) && (count < plen) && all_eq;

endmodule

// ===== design/stream_find_replace.sv =====
// Streaming find-and-replace: top level with sequencer, held bytes and output stage.
// Depends on sfr_pkg and sfr_match.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one byte per beat, with a
//   final flag on the last byte of a string. Output channel (out_valid/
//   out_ready/out_data) gives bytes with byte_valid, run_last and string_end.
//   Configuration is to be written through cfg_we/cfg_index/cfg_data while idle,
//   unchecked by the block; a pattern length write is ignored while any byte is held.
// Sequencing:
//   One input beat at a time. After acceptance the byte is appended, then the
//   held bytes are checked; each check, each released, replacement or flushed byte,
//   the end of the flush step and the run close are each a separate step, and the
//   next beat is taken only once the run has closed. A result waits in
//   a one-deep pending register until the next one is produced or the run
//   closes, and a passed-through byte reaches out_data from that register.
//   A stalled receiver holds the sequencer at its next result.
// Reset:
//   Clears held count, configuration registers and both output stages.
module stream_find_replace #(
    parameter int unsigned PATTERN_MAX = 8,
    parameter int unsigned REPLACE_MAX = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sfr_pkg::in_beat_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output sfr_pkg::out_beat_t          out_data,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [sfr_pkg::WORD_W-1:0]  cfg_data
);

    localparam logic [sfr_pkg::LEN_W-1:0] PMAX = sfr_pkg::LEN_W'(PATTERN_MAX);
    localparam logic [sfr_pkg::LEN_W-1:0] RMAX = sfr_pkg::LEN_W'(REPLACE_MAX);

    // configuration registers
    logic [sfr_pkg::WORD_W-1:0] pat_bytes_reg;
    logic [sfr_pkg::LEN_W-1:0]  pat_len_reg;
    logic [sfr_pkg::WORD_W-1:0] rep_bytes_reg;
    logic [sfr_pkg::LEN_W-1:0]  rep_len_reg;

    // sequencer state
    sfr_pkg::state_t            state_reg, state_next;
    logic [sfr_pkg::BYTE_W-1:0] held_reg  [PATTERN_MAX];
    logic [sfr_pkg::BYTE_W-1:0] held_next [PATTERN_MAX];
    logic [sfr_pkg::LEN_W-1:0]  count_reg, count_next;
    logic [sfr_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                       final_reg, final_next;
    logic [sfr_pkg::RIDX_W-1:0] ridx_reg, ridx_next;
    logic [sfr_pkg::NCNT_W-1:0] n_reg, n_next;

    // pending result and output register
    logic                       pend_valid_reg, pend_valid_next;
    logic [sfr_pkg::BYTE_W-1:0] pend_byte_reg, pend_byte_next;
    logic                       out_valid_reg, out_valid_next;
    sfr_pkg::out_beat_t         out_data_reg, out_data_next;

    logic [sfr_pkg::LEN_W-1:0]  plen;
    logic [sfr_pkg::LEN_W-1:0]  rlen;
    logic [PATTERN_MAX-1:0][sfr_pkg::BYTE_W-1:0] held_flat;
    sfr_pkg::match_t            match;
    logic                       out_free;
    logic                       emit_ok;
    logic                       emit_req;
    logic [sfr_pkg::BYTE_W-1:0] emit_byte;
    logic                       do_shift;
    logic [sfr_pkg::LEN_W-1:0]  shift_amt;
    logic [sfr_pkg::BYTE_W-1:0] rep_byte;

    // clamp lengths
    assign plen = (pat_len_reg > PMAX) ? PMAX : pat_len_reg;
    assign rlen = (rep_len_reg > RMAX) ? RMAX : rep_len_reg;

    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            held_flat[i] = held_reg[i];
        end
    end

    // shared compare unit
    sfr_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .held    (held_flat),
        .count   (count_reg),
        .plen    (plen),
        .pattern (pat_bytes_reg),
        .result  (match)
    );

    assign rep_byte = rep_bytes_reg[{ridx_reg, 3'b000} +: sfr_pkg::BYTE_W];

    assign out_free  = !out_valid_reg || out_ready;
    assign emit_ok   = (n_reg >= sfr_pkg::RESULT_LIMIT) || !pend_valid_reg || out_free;
    assign in_ready  = (state_reg == sfr_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= '0;
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sfr_pkg::CFG_PATTERN_BYTES:
                begin
                    pat_bytes_reg <= cfg_data;
                end
                sfr_pkg::CFG_PATTERN_LENGTH:
                begin
                    if (count_reg == '0)
                    begin
                        pat_len_reg <= cfg_data[sfr_pkg::LEN_W-1:0];
                    end
                end
                sfr_pkg::CFG_REPLACEMENT_BYTES:
                begin
                    rep_bytes_reg <= cfg_data;
                end
                sfr_pkg::CFG_REPLACEMENT_LENGTH:
                begin
                    rep_len_reg <= cfg_data[sfr_pkg::LEN_W-1:0];
                end
                default:
                begin
                    pat_len_reg <= pat_len_reg;
                end
            endcase
        end
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sfr_pkg::ST_IDLE;
            count_reg      <= '0;
            n_reg          <= '0;
            ridx_reg       <= '0;
            final_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            n_reg          <= n_next;
            ridx_reg       <= ridx_next;
            final_reg      <= final_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            held_reg[i] <= held_next[i];
        end
        byte_reg      <= byte_next;
        pend_byte_reg <= pend_byte_next;
        out_data_reg  <= out_data_next;
    end

    // sequencer: one loop step per cycle while the output does not stall an emit
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        byte_next       = byte_reg;
        final_next      = final_reg;
        ridx_next       = ridx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        emit_req        = 1'b0;
        emit_byte       = '0;
        do_shift        = 1'b0;
        shift_amt       = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            held_next[i] = held_reg[i];
        end

        case (state_reg)
            sfr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next  = in_data.in_byte;
                    final_next = in_data.in_final;
                    n_next     = '0;
                    ridx_next  = '0;
                    state_next = sfr_pkg::ST_APPEND;
                end
            end

            sfr_pkg::ST_APPEND:
            begin
                if (count_reg >= PMAX)
                begin
                    // buffer full: release the earliest byte first
                    emit_req  = 1'b1;
                    emit_byte = held_reg[0];
                    if (emit_ok)
                    begin
                        do_shift   = 1'b1;
                        shift_amt  = sfr_pkg::LEN_W'(1);
                        count_next = count_reg - sfr_pkg::LEN_W'(1);
                    end
                end
                else
                begin
                    for (int i = 0; i < PATTERN_MAX; i++)
                    begin
                        if (count_reg == sfr_pkg::LEN_W'(i))
                        begin
                            held_next[i] = byte_reg;
                        end
                    end
                    count_next = count_reg + sfr_pkg::LEN_W'(1);
                    state_next = sfr_pkg::ST_CHECK;
                end
            end

            sfr_pkg::ST_CHECK:
            begin
                if (count_reg == '0)
                begin
                    state_next = sfr_pkg::ST_FLUSH;
                end
                else if (match.full)
                begin
                    if (rlen == '0)
                    begin
                        do_shift   = 1'b1;
                        shift_amt  = plen;
                        count_next = count_reg - plen;
                    end
                    else
                    begin
                        ridx_next  = '0;
                        state_next = sfr_pkg::ST_REPL;
                    end
                end
                else if (match.partial)
                begin
                    state_next = sfr_pkg::ST_FLUSH;
                end
                else
                begin
                    emit_req  = 1'b1;
                    emit_byte = held_reg[0];
                    if (emit_ok)
                    begin
                        do_shift   = 1'b1;
                        shift_amt  = sfr_pkg::LEN_W'(1);
                        count_next = count_reg - sfr_pkg::LEN_W'(1);
                    end
                end
            end

            sfr_pkg::ST_REPL:
            begin
                emit_req  = 1'b1;
                emit_byte = rep_byte;
                if (emit_ok)
                begin
                    if ({1'b0, ridx_reg} + sfr_pkg::LEN_W'(1) == rlen)
                    begin
                        do_shift   = 1'b1;
                        shift_amt  = plen;
                        count_next = count_reg - plen;
                        state_next = sfr_pkg::ST_CHECK;
                    end
                    else
                    begin
                        ridx_next = ridx_reg + sfr_pkg::RIDX_W'(1);
                    end
                end
            end

            sfr_pkg::ST_FLUSH:
            begin
                if (!final_reg || count_reg == '0)
                begin
                    if (final_reg)
                    begin
                        count_next = '0;
                    end
                    state_next = sfr_pkg::ST_FINISH;
                end
                else
                begin
                    emit_req  = 1'b1;
                    emit_byte = held_reg[0];
                    if (emit_ok)
                    begin
                        do_shift   = 1'b1;
                        shift_amt  = sfr_pkg::LEN_W'(1);
                        count_next = count_reg - sfr_pkg::LEN_W'(1);
                    end
                end
            end

            sfr_pkg::ST_FINISH:
            begin
                // close the run: last pending byte, or a bare end marker
                if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_data_next   = '{out_byte:   pend_byte_reg,
                                            byte_valid: 1'b1,
                                            run_last:   1'b1,
                                            string_end: final_reg};
                        pend_valid_next = 1'b0;
                        state_next      = sfr_pkg::ST_IDLE;
                    end
                end
                else if (final_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{out_byte:   '0,
                                           byte_valid: 1'b0,
                                           run_last:   1'b1,
                                           string_end: 1'b1};
                        state_next     = sfr_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = sfr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sfr_pkg::ST_IDLE;
            end
        endcase

        // emit: older pending byte moves to the output register
        if (emit_req && emit_ok && n_reg < sfr_pkg::RESULT_LIMIT)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = '{out_byte:   pend_byte_reg,
                                   byte_valid: 1'b1,
                                   run_last:   1'b0,
                                   string_end: 1'b0};
            end
            pend_valid_next = 1'b1;
            pend_byte_next  = emit_byte;
            n_next          = n_reg + sfr_pkg::NCNT_W'(1);
        end

        // drop bytes from the front of the held buffer
        if (do_shift)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                for (int s = 1; i + s < PATTERN_MAX; s++)
                begin
                    if (shift_amt == sfr_pkg::LEN_W'(s))
                    begin
                        held_next[i] = held_reg[i + s];
                    end
                end
            end
        end
    end

endmodule
